/* rtl/mmb_pkg.sv */
// ----------------------------------------------------------------------------
// mmb_pkg
// Shared types, request codes and MIDI constants for the message builder.
// ----------------------------------------------------------------------------
package mmb_pkg;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
    localparam int unsigned STEP_W = 5;

    localparam logic [4:0] F_NOTEOFF   = 5'd0;
    localparam logic [4:0] F_NOTEON    = 5'd1;
    localparam logic [4:0] F_POLYPRESS = 5'd2;
    localparam logic [4:0] F_CC        = 5'd3;
    localparam logic [4:0] F_PROG      = 5'd4;
    localparam logic [4:0] F_CHANPRESS = 5'd5;
    localparam logic [4:0] F_BEND      = 5'd6;
    localparam logic [4:0] F_CC14      = 5'd7;
    localparam logic [4:0] F_RPN       = 5'd8;
    localparam logic [4:0] F_NRPN      = 5'd9;
    localparam logic [4:0] F_SONGPOS   = 5'd10;
    localparam logic [4:0] F_SONGSEL   = 5'd11;
    localparam logic [4:0] F_TUNE      = 5'd12;
    localparam logic [4:0] F_CLOCK     = 5'd13;
    localparam logic [4:0] F_START     = 5'd14;
    localparam logic [4:0] F_CONT      = 5'd15;
    localparam logic [4:0] F_STOP      = 5'd16;
    localparam logic [4:0] F_SENSING   = 5'd17;
    localparam logic [4:0] F_SYSRESET  = 5'd18;
    localparam logic [4:0] F_PANIC     = 5'd19;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_PARAM = 2'd1;
    localparam logic [1:0] ERR_MSG   = 2'd2;
    localparam logic [1:0] ERR_NODEV = 2'd3;

    localparam logic [1:0] OP_SINGLE = 2'd0;
    localparam logic [1:0] OP_CC14   = 2'd1;
    localparam logic [1:0] OP_RPN    = 2'd2;
    localparam logic [1:0] OP_PANIC  = 2'd3;

    localparam logic [3:0] ST_NOTEOFF   = 4'h8;
    localparam logic [3:0] ST_NOTEON    = 4'h9;
    localparam logic [3:0] ST_POLYPRESS = 4'hA;
    localparam logic [3:0] ST_CC        = 4'hB;
    localparam logic [3:0] ST_PROG      = 4'hC;
    localparam logic [3:0] ST_CHANPRESS = 4'hD;
    localparam logic [3:0] ST_BEND      = 4'hE;

    localparam logic [7:0] ST_SONGPOS  = 8'hF2;
    localparam logic [7:0] ST_SONGSEL  = 8'hF3;
    localparam logic [7:0] ST_TUNE     = 8'hF6;
    localparam logic [7:0] ST_CLOCK    = 8'hF8;
    localparam logic [7:0] ST_START    = 8'hFA;
    localparam logic [7:0] ST_CONT     = 8'hFB;
    localparam logic [7:0] ST_STOP     = 8'hFC;
    localparam logic [7:0] ST_SENSING  = 8'hFE;
    localparam logic [7:0] ST_SYSRESET = 8'hFF;

    localparam logic [6:0] CC_RPN_MSB    = 7'd101;
    localparam logic [6:0] CC_RPN_LSB    = 7'd100;
    localparam logic [6:0] CC_NRPN_MSB   = 7'd99;
    localparam logic [6:0] CC_NRPN_LSB   = 7'd98;
    localparam logic [6:0] CC_DATA_MSB   = 7'd6;
    localparam logic [6:0] CC_DATA_LSB   = 7'd38;
    localparam logic [6:0] CC_SUSTAIN    = 7'd64;
    localparam logic [6:0] CC_NOTES_OFF  = 7'd123;
    localparam logic [6:0] CC_LSB_OFFSET = 7'h20;
    localparam logic [6:0] DATA_NULL     = 7'h7F;

    localparam logic [STEP_W-1:0] CC14_LAST  = STEP_W'(1);
    localparam logic [STEP_W-1:0] RPN_LAST   = STEP_W'(5);
    localparam logic [STEP_W-1:0] PANIC_LAST = STEP_W'(31);

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  status;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [1:0]  cnt;
        logic [6:0]  ctl_lo;
        logic [13:0] num;
        logic [13:0] val;
        logic [1:0]  err;
        logic [63:0] ts;
    } mmb_desc_t;

endpackage

/* rtl/mmb_front.sv */
// ----------------------------------------------------------------------------
// mmb_front
// Checks one request and reduces it to a descriptor for the back end.
// ----------------------------------------------------------------------------
module mmb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic [4:0]        func,
    input  logic [4:0]        channel,
    input  logic [7:0]        key,
    input  logic [15:0]       amount,
    input  logic [15:0]       param_number,
    input  logic [63:0]       timestamp,
    output mmb_pkg::mmb_desc_t desc
);
    import mmb_pkg::*;

    logic       port_open_reg;
    logic       port_open_next;
    logic       ch_ok;
    logic [3:0] cn;
    logic       key7;
    logic       amt7;
    logic       amt14;
    logic       num14;
    logic [1:0] err_n;
    mmb_desc_t  d;

    assign cfg_ready      = 1'b1;
    assign port_open_next = (cfg_valid && cfg_ready) ? cfg_data : port_open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_open_reg <= 1'b0;
        end
        else
        begin
            port_open_reg <= port_open_next;
        end
    end

    assign ch_ok = (channel >= 5'd1) && (channel <= 5'd16);
    assign cn    = 4'(channel - 5'd1);
    assign key7  = ~key[7];
    assign amt7  = (amount[15:7] == 9'd0);
    assign amt14 = (amount[15:14] == 2'd0);
    assign num14 = (param_number[15:14] == 2'd0);

    always_comb
    begin
        d        = '0;
        d.op     = OP_SINGLE;
        d.ts     = timestamp;
        d.num    = param_number[13:0];
        d.val    = amount[13:0];
        err_n    = ERR_OK;
        unique case (func) inside
            F_NOTEOFF, F_NOTEON, F_POLYPRESS, F_CC:
            begin
                if (!ch_ok || !key7 || !amt7)
                begin
                    err_n = ERR_MSG;
                end
                unique case (func[1:0])
                    2'd0:    d.status = {ST_NOTEOFF, cn};
                    2'd1:    d.status = {ST_NOTEON, cn};
                    2'd2:    d.status = {ST_POLYPRESS, cn};
                    default: d.status = {ST_CC, cn};
                endcase
                d.d1  = key[6:0];
                d.d2  = amount[6:0];
                d.cnt = 2'd3;
            end
            F_PROG:
            begin
                if (!ch_ok || !key7)
                begin
                    err_n = ERR_MSG;
                end
                d.status = {ST_PROG, cn};
                d.d1     = key[6:0];
                d.cnt    = 2'd2;
            end
            F_CHANPRESS:
            begin
                if (!ch_ok || !amt7)
                begin
                    err_n = ERR_MSG;
                end
                d.status = {ST_CHANPRESS, cn};
                d.d1     = amount[6:0];
                d.cnt    = 2'd2;
            end
            F_BEND:
            begin
                if (!ch_ok || !amt14)
                begin
                    err_n = ERR_MSG;
                end
                d.status = {ST_BEND, cn};
                d.d1     = amount[6:0];
                d.d2     = amount[13:7];
                d.cnt    = 2'd3;
            end
            F_CC14:
            begin
                if (!ch_ok || (key[7:5] != 3'd0) || !amt14)
                begin
                    err_n = ERR_MSG;
                end
                d.op     = OP_CC14;
                d.status = {ST_CC, cn};
                d.d1     = key[6:0];
                d.cnt    = 2'd3;
            end
            F_RPN, F_NRPN:
            begin
                if (!ch_ok)
                begin
                    err_n = ERR_PARAM;
                end
                else if (!num14 || !amt14)
                begin
                    err_n = ERR_MSG;
                end
                d.op     = OP_RPN;
                d.status = {ST_CC, cn};
                d.d1     = (func == F_RPN) ? CC_RPN_MSB : CC_NRPN_MSB;
                d.ctl_lo = (func == F_RPN) ? CC_RPN_LSB : CC_NRPN_LSB;
                d.cnt    = 2'd3;
            end
            F_SONGPOS:
            begin
                if (!amt14)
                begin
                    err_n = ERR_MSG;
                end
                d.status = ST_SONGPOS;
                d.d1     = amount[6:0];
                d.d2     = amount[13:7];
                d.cnt    = 2'd3;
            end
            F_SONGSEL:
            begin
                if (!key7)
                begin
                    err_n = ERR_MSG;
                end
                d.status = ST_SONGSEL;
                d.d1     = key[6:0];
                d.cnt    = 2'd2;
            end
            F_TUNE, F_CLOCK, F_START, F_CONT, F_STOP, F_SENSING, F_SYSRESET:
            begin
                unique case (func)
                    F_TUNE:    d.status = ST_TUNE;
                    F_CLOCK:   d.status = ST_CLOCK;
                    F_START:   d.status = ST_START;
                    F_CONT:    d.status = ST_CONT;
                    F_STOP:    d.status = ST_STOP;
                    F_SENSING: d.status = ST_SENSING;
                    default:   d.status = ST_SYSRESET;
                endcase
                d.cnt = 2'd1;
            end
            F_PANIC:
            begin
                d.op  = OP_PANIC;
                d.cnt = 2'd3;
                d.ts  = '0;
            end
            default:
            begin
                err_n = ERR_MSG;
            end
        endcase

        if (err_n == ERR_OK && !port_open_reg)
        begin
            err_n = ERR_NODEV;
        end

        desc = d;
        if (err_n != ERR_OK)
        begin
            desc     = '0;
            desc.op  = OP_SINGLE;
            desc.err = err_n;
        end
    end

endmodule

/* rtl/mmb_queue.sv */
// ----------------------------------------------------------------------------
// mmb_queue
// Short descriptor queue between the front and back ends.
// ----------------------------------------------------------------------------
module mmb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mmb_pkg::mmb_desc_t push_data,
    input  logic               pop,
    output mmb_pkg::mmb_desc_t head,
    output logic               not_empty,
    output logic               full
);
    import mmb_pkg::*;

    mmb_desc_t         entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/mmb_back.sv */
// ----------------------------------------------------------------------------
// mmb_back
// Expands the queue head into MIDI messages, one per cycle, registered out.
// ----------------------------------------------------------------------------
module mmb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mmb_pkg::mmb_desc_t head,
    input  logic               q_valid,
    output logic               pop,
    output logic               result_valid,
    output logic [7:0]         status_byte,
    output logic [6:0]         data_first,
    output logic [6:0]         data_second,
    output logic [1:0]         byte_count,
    output logic [63:0]        send_time,
    output logic [1:0]         error_code,
    output logic               last
);
    import mmb_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              valid_reg;
    logic [7:0]        st_reg;
    logic [6:0]        d1_reg;
    logic [6:0]        d2_reg;
    logic [1:0]        cnt_reg;
    logic [63:0]       ts_reg;
    logic [1:0]        err_reg;
    logic              last_reg;
    logic [7:0]        st_n;
    logic [6:0]        d1_n;
    logic [6:0]        d2_n;
    logic              last_n;

    always_comb
    begin
        st_n   = head.status;
        d1_n   = head.d1;
        d2_n   = head.d2;
        last_n = 1'b1;
        unique case (head.op)
            OP_CC14:
            begin
                d1_n   = step_reg[0] ? (head.d1 | CC_LSB_OFFSET) : head.d1;
                d2_n   = step_reg[0] ? head.val[6:0] : head.val[13:7];
                last_n = (step_reg == CC14_LAST);
            end
            OP_RPN:
            begin
                unique case (step_reg[2:0])
                    3'd0:
                    begin
                        d1_n = head.d1;
                        d2_n = head.num[13:7];
                    end
                    3'd1:
                    begin
                        d1_n = head.ctl_lo;
                        d2_n = head.num[6:0];
                    end
                    3'd2:
                    begin
                        d1_n = CC_DATA_MSB;
                        d2_n = head.val[13:7];
                    end
                    3'd3:
                    begin
                        d1_n = CC_DATA_LSB;
                        d2_n = head.val[6:0];
                    end
                    3'd4:
                    begin
                        d1_n = head.d1;
                        d2_n = DATA_NULL;
                    end
                    default:
                    begin
                        d1_n = head.ctl_lo;
                        d2_n = DATA_NULL;
                    end
                endcase
                last_n = (step_reg == RPN_LAST);
            end
            OP_PANIC:
            begin
                st_n   = {ST_CC, step_reg[4:1]};
                d1_n   = step_reg[0] ? CC_SUSTAIN : CC_NOTES_OFF;
                d2_n   = '0;
                last_n = (step_reg == PANIC_LAST);
            end
            default:
            begin
                last_n = 1'b1;
            end
        endcase
    end

    assign pop       = q_valid && last_n;
    assign step_next = !q_valid ? step_reg : (last_n ? '0 : step_reg + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid)
        begin
            st_reg   <= st_n;
            d1_reg   <= d1_n;
            d2_reg   <= d2_n;
            cnt_reg  <= head.cnt;
            ts_reg   <= head.ts;
            err_reg  <= head.err;
            last_reg <= last_n;
        end
    end

    assign result_valid = valid_reg;
    assign status_byte  = st_reg;
    assign data_first   = d1_reg;
    assign data_second  = d2_reg;
    assign byte_count   = cnt_reg;
    assign send_time    = ts_reg;
    assign error_code   = err_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> step_reg == '0)
        else $error("step counter moved with empty queue");

    a_cc14_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && head.op == OP_CC14 |-> step_reg <= CC14_LAST)
        else $error("cc14 sequence overran");

    a_rpn_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && head.op == OP_RPN |-> step_reg <= RPN_LAST)
        else $error("rpn sequence overran");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && err_reg != ERR_OK |-> cnt_reg == 2'd0 && last_reg)
        else $error("error result not a single empty message");

    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |=> valid_reg)
        else $error("message lost between queue and output");
`endif

endmodule

/* rtl/midi_message_builder.sv */
// ----------------------------------------------------------------------------
// midi_message_builder
// MIDI 1.0 channel and system message encoder with a decoupled back end.
// ----------------------------------------------------------------------------
//  channel   handshake                   transfer at clock edge
//  request   start / busy                start && !busy
//  config    cfg_valid / cfg_ready       cfg_valid && cfg_ready (ready tied high)
//  result    result_valid strobe         every cycle result_valid is high
//
//  A request enters the queue at its transfer; the back end registers its
//  messages out once it reaches the queue head, one message per cycle:
//  1 for plain kinds and errors, 2 for cc14, 6 for rpn/nrpn, 32 for panic,
//  so requests sustain one per cycle when each yields one message. busy
//  rises only when the 2-entry queue is full behind a multi-message request.
//  Reset clears the queue, the sequence counter and port_open.
// ----------------------------------------------------------------------------
module midi_message_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  func,
    input  logic [4:0]  channel,
    input  logic [7:0]  key,
    input  logic [15:0] amount,
    input  logic [15:0] param_number,
    input  logic [63:0] timestamp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    output logic        result_valid,
    output logic [7:0]  status_byte,
    output logic [6:0]  data_first,
    output logic [6:0]  data_second,
    output logic [1:0]  byte_count,
    output logic [63:0] send_time,
    output logic [1:0]  error_code,
    output logic        last
);
    import mmb_pkg::*;

    mmb_desc_t desc;
    mmb_desc_t head;
    logic      q_valid;
    logic      q_full;
    logic      pop;

    assign busy = q_full;

    mmb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .func         (func),
        .channel      (channel),
        .key          (key),
        .amount       (amount),
        .param_number (param_number),
        .timestamp    (timestamp),
        .desc         (desc)
    );

    mmb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start && !q_full),
        .push_data (desc),
        .pop       (pop),
        .head      (head),
        .not_empty (q_valid),
        .full      (q_full)
    );

    mmb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_valid      (q_valid),
        .pop          (pop),
        .result_valid (result_valid),
        .status_byte  (status_byte),
        .data_first   (data_first),
        .data_second  (data_second),
        .byte_count   (byte_count),
        .send_time    (send_time),
        .error_code   (error_code),
        .last         (last)
    );

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for midi_message_builder. A directed table covers
// field extremes, every request kind and the error paths. Random requests
// then run over several port_open settings and idle mixes. Every result
// strobe is checked field by field against the table or an in-bench encoder.
// ----------------------------------------------------------------------------
module tb_top;

    import mmb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DIR_N       = 26;
    localparam int unsigned DIR_OPEN_AT = 3;
    localparam int unsigned PHASES      = 4;
    localparam int unsigned PHASE_ITEMS = 61;
    localparam int unsigned DRAIN_WAIT  = 8;
    localparam logic [4:0]  F_BAD_FUNC  = 5'd31;

    typedef struct packed {
        logic [4:0]  func;
        logic [4:0]  chan;
        logic [7:0]  key;
        logic [15:0] amt;
        logic [15:0] num;
        logic [63:0] stamp;
    } midi_req_t;

    typedef struct packed {
        logic [7:0]  status;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [1:0]  cnt;
        logic [63:0] stamp;
        logic [1:0]  err;
        logic        last;
    } midi_msg_t;

    typedef struct packed {
        midi_req_t  req;
        logic       typed;
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        logic [1:0] cnt;
        logic [1:0] err;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [DIR_N] = '{
        '{'{F_NOTEON,    5'd1,  8'd60,  16'd100,   16'd0,     64'h1},
          1'b1, 8'h00, 7'd0,   7'd0,   2'd0, ERR_NODEV},
        '{'{F_PANIC,     5'd0,  8'd0,   16'd0,     16'd0,     64'h2},
          1'b1, 8'h00, 7'd0,   7'd0,   2'd0, ERR_NODEV},
        '{'{F_RPN,       5'd17, 8'd0,   16'd0,     16'd0,     64'h3},
          1'b1, 8'h00, 7'd0,   7'd0,   2'd0, ERR_PARAM},
        '{'{F_NOTEOFF,   5'd1,  8'd0,   16'd0,     16'd0,     64'h0},
          1'b1, 8'h80, 7'd0,   7'd0,   2'd3, ERR_OK},
        '{'{F_NOTEON,    5'd16, 8'd127, 16'd127,   16'd0,     64'hFFFF_FFFF_FFFF_FFFF},
          1'b1, 8'h9F, 7'd127, 7'd127, 2'd3, ERR_OK},
        '{'{F_POLYPRESS, 5'd5,  8'd128, 16'd0,     16'd0,     64'h10},
          1'b1, 8'h00, 7'd0,   7'd0,   2'd0, ERR_MSG},
        '{'{F_CC,        5'd3,  8'd7,   16'd128,   16'd0,     64'h11},
          1'b1, 8'h00, 7'd0,   7'd0,   2'd0, ERR_MSG},
        '{'{F_PROG,      5'd16, 8'd127, 16'hFFFF,  16'hFFFF,  64'h12},
          1'b1, 8'hCF, 7'd127, 7'd0,   2'd2, ERR_OK},
        '{'{F_CHANPRESS, 5'd1,  8'd255, 16'd127,   16'd0,     64'h13},
          1'b1, 8'hD0, 7'd127, 7'd0,   2'd2, ERR_OK},
        '{'{F_BEND,      5'd1,  8'd0,   16'd16383, 16'd0,     64'h8000_0000_0000_0000},
          1'b1, 8'hE0, 7'd127, 7'd127, 2'd3, ERR_OK},
        '{'{F_CC14,      5'd1,  8'd31,  16'd16383, 16'd0,     64'h15},
          1'b0, 8'h00, 7'd0,   7'd0,   2'd0, ERR_OK},
        '{'{F_CC14,      5'd2,  8'd32,  16'd0,     16'd0,     64'h16},
          1'b1, 8'h00, 7'd0,   7'd0,   2'd0, ERR_MSG},
        '{'{F_RPN,       5'd1,  8'd0,   16'd0,     16'd16383, 64'h17},
          1'b0, 8'h00, 7'd0,   7'd0,   2'd0, ERR_OK},
        '{'{F_NRPN,      5'd16, 8'd0,   16'd16383, 16'd0,     64'h18},
          1'b0, 8'h00, 7'd0,   7'd0,   2'd0, ERR_OK},
        '{'{F_RPN,       5'd1,  8'd0,   16'd0,     16'd16384, 64'h19},
          1'b1, 8'h00, 7'd0,   7'd0,   2'd0, ERR_MSG},
        '{'{F_SONGPOS,   5'd0,  8'd0,   16'd16383, 16'd0,     64'h1A},
          1'b1, 8'hF2, 7'd127, 7'd127, 2'd3, ERR_OK},
        '{'{F_SONGSEL,   5'd31, 8'd128, 16'd0,     16'd0,     64'h1B},
          1'b1, 8'h00, 7'd0,   7'd0,   2'd0, ERR_MSG},
        '{'{F_PANIC,     5'd31, 8'd255, 16'hFFFF,  16'hFFFF,  64'h1C},
          1'b0, 8'h00, 7'd0,   7'd0,   2'd0, ERR_OK},
        '{'{F_BAD_FUNC,  5'd1,  8'd0,   16'd0,     16'd0,     64'h1D},
          1'b1, 8'h00, 7'd0,   7'd0,   2'd0, ERR_MSG},
        '{'{F_TUNE,      5'd0,  8'd0,   16'd0,     16'd0,     64'h20},
          1'b1, ST_TUNE,     7'd0, 7'd0, 2'd1, ERR_OK},
        '{'{F_CLOCK,     5'd0,  8'd0,   16'd0,     16'd0,     64'h21},
          1'b1, ST_CLOCK,    7'd0, 7'd0, 2'd1, ERR_OK},
        '{'{F_START,     5'd0,  8'd0,   16'd0,     16'd0,     64'h22},
          1'b1, ST_START,    7'd0, 7'd0, 2'd1, ERR_OK},
        '{'{F_CONT,      5'd0,  8'd0,   16'd0,     16'd0,     64'h23},
          1'b1, ST_CONT,     7'd0, 7'd0, 2'd1, ERR_OK},
        '{'{F_STOP,      5'd0,  8'd0,   16'd0,     16'd0,     64'h24},
          1'b1, ST_STOP,     7'd0, 7'd0, 2'd1, ERR_OK},
        '{'{F_SENSING,   5'd0,  8'd0,   16'd0,     16'd0,     64'h25},
          1'b1, ST_SENSING,  7'd0, 7'd0, 2'd1, ERR_OK},
        '{'{F_SYSRESET,  5'd0,  8'd0,   16'd0,     16'd0,     64'h26},
          1'b1, ST_SYSRESET, 7'd0, 7'd0, 2'd1, ERR_OK}
    };

    localparam logic PH_OPEN [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1};
    localparam int   PH_IDLE [PHASES] = '{0, 74, 0, 36};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [4:0]  func = '0;
    logic [4:0]  channel = '0;
    logic [7:0]  key = '0;
    logic [15:0] amount = '0;
    logic [15:0] param_number = '0;
    logic [63:0] timestamp = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        result_valid;
    logic [7:0]  status_byte;
    logic [6:0]  data_first;
    logic [6:0]  data_second;
    logic [1:0]  byte_count;
    logic [63:0] send_time;
    logic [1:0]  error_code;
    logic        last;

    midi_msg_t   want_msgs [$];
    midi_msg_t   want;
    midi_msg_t   dir_want;
    logic        port_is_open = 1'b0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    midi_message_builder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .channel      (channel),
        .key          (key),
        .amount       (amount),
        .param_number (param_number),
        .timestamp    (timestamp),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .status_byte  (status_byte),
        .data_first   (data_first),
        .data_second  (data_second),
        .byte_count   (byte_count),
        .send_time    (send_time),
        .error_code   (error_code),
        .last         (last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic midi_msg_t mk_msg(input logic [7:0] status, input logic [6:0] d1,
                                         input logic [6:0] d2, input logic [1:0] cnt,
                                         input logic [63:0] stamp);
        midi_msg_t m;
        m.status = status;
        m.d1     = d1;
        m.d2     = d2;
        m.cnt    = cnt;
        m.stamp  = stamp;
        m.err    = ERR_OK;
        m.last   = 1'b0;
        return m;
    endfunction

    function automatic midi_msg_t err_msg(input logic [1:0] code);
        midi_msg_t m;
        m      = mk_msg(8'h00, 7'd0, 7'd0, 2'd0, 64'd0);
        m.err  = code;
        m.last = 1'b1;
        return m;
    endfunction

    // Encodes one request into the MIDI messages it should produce.
    function automatic void predict_request(input midi_req_t r);
        midi_msg_t  seq [$];
        logic [1:0] fail;
        logic       ch_ok;
        logic [3:0] cn;
        logic [3:0] nib;
        logic [7:0] sb;
        logic [6:0] hi;
        logic [6:0] lo;
        fail  = ERR_OK;
        ch_ok = (r.chan >= 5'd1) && (r.chan <= 5'd16);
        cn    = 4'(r.chan - 5'd1);
        sb    = {ST_CC, cn};
        hi    = (r.func == F_RPN) ? CC_RPN_MSB : CC_NRPN_MSB;
        lo    = (r.func == F_RPN) ? CC_RPN_LSB : CC_NRPN_LSB;
        case (r.func)
            F_NOTEOFF, F_NOTEON, F_POLYPRESS, F_CC:
            begin
                case (r.func)
                    F_NOTEOFF:   nib = ST_NOTEOFF;
                    F_NOTEON:    nib = ST_NOTEON;
                    F_POLYPRESS: nib = ST_POLYPRESS;
                    default:     nib = ST_CC;
                endcase
                if (!ch_ok || r.key > 8'd127 || r.amt > 16'd127)
                    fail = ERR_MSG;
                else
                    seq.push_back(mk_msg({nib, cn}, r.key[6:0], r.amt[6:0], 2'd3, r.stamp));
            end
            F_PROG:
            begin
                if (!ch_ok || r.key > 8'd127)
                    fail = ERR_MSG;
                else
                    seq.push_back(mk_msg({ST_PROG, cn}, r.key[6:0], 7'd0, 2'd2, r.stamp));
            end
            F_CHANPRESS:
            begin
                if (!ch_ok || r.amt > 16'd127)
                    fail = ERR_MSG;
                else
                    seq.push_back(mk_msg({ST_CHANPRESS, cn}, r.amt[6:0], 7'd0, 2'd2,
                                         r.stamp));
            end
            F_BEND:
            begin
                if (!ch_ok || r.amt > 16'd16383)
                    fail = ERR_MSG;
                else
                    seq.push_back(mk_msg({ST_BEND, cn}, r.amt[6:0], r.amt[13:7], 2'd3,
                                         r.stamp));
            end
            F_CC14:
            begin
                if (!ch_ok || r.key > 8'd31 || r.amt > 16'd16383)
                    fail = ERR_MSG;
                else
                begin
                    seq.push_back(mk_msg(sb, r.key[6:0], r.amt[13:7], 2'd3, r.stamp));
                    seq.push_back(mk_msg(sb, r.key[6:0] + CC_LSB_OFFSET, r.amt[6:0], 2'd3,
                                         r.stamp));
                end
            end
            F_RPN, F_NRPN:
            begin
                if (!ch_ok)
                    fail = ERR_PARAM;
                else if (r.num > 16'd16383 || r.amt > 16'd16383)
                    fail = ERR_MSG;
                else
                begin
                    seq.push_back(mk_msg(sb, hi, r.num[13:7], 2'd3, r.stamp));
                    seq.push_back(mk_msg(sb, lo, r.num[6:0], 2'd3, r.stamp));
                    seq.push_back(mk_msg(sb, CC_DATA_MSB, r.amt[13:7], 2'd3, r.stamp));
                    seq.push_back(mk_msg(sb, CC_DATA_LSB, r.amt[6:0], 2'd3, r.stamp));
                    seq.push_back(mk_msg(sb, hi, DATA_NULL, 2'd3, r.stamp));
                    seq.push_back(mk_msg(sb, lo, DATA_NULL, 2'd3, r.stamp));
                end
            end
            F_SONGPOS:
            begin
                if (r.amt > 16'd16383)
                    fail = ERR_MSG;
                else
                    seq.push_back(mk_msg(ST_SONGPOS, r.amt[6:0], r.amt[13:7], 2'd3, r.stamp));
            end
            F_SONGSEL:
            begin
                if (r.key > 8'd127)
                    fail = ERR_MSG;
                else
                    seq.push_back(mk_msg(ST_SONGSEL, r.key[6:0], 7'd0, 2'd2, r.stamp));
            end
            F_TUNE:     seq.push_back(mk_msg(ST_TUNE, 7'd0, 7'd0, 2'd1, r.stamp));
            F_CLOCK:    seq.push_back(mk_msg(ST_CLOCK, 7'd0, 7'd0, 2'd1, r.stamp));
            F_START:    seq.push_back(mk_msg(ST_START, 7'd0, 7'd0, 2'd1, r.stamp));
            F_CONT:     seq.push_back(mk_msg(ST_CONT, 7'd0, 7'd0, 2'd1, r.stamp));
            F_STOP:     seq.push_back(mk_msg(ST_STOP, 7'd0, 7'd0, 2'd1, r.stamp));
            F_SENSING:  seq.push_back(mk_msg(ST_SENSING, 7'd0, 7'd0, 2'd1, r.stamp));
            F_SYSRESET: seq.push_back(mk_msg(ST_SYSRESET, 7'd0, 7'd0, 2'd1, r.stamp));
            F_PANIC:
            begin
                for (int c = 0; c < 16; c++)
                begin
                    seq.push_back(mk_msg({ST_CC, 4'(c)}, CC_NOTES_OFF, 7'd0, 2'd3, 64'd0));
                    seq.push_back(mk_msg({ST_CC, 4'(c)}, CC_SUSTAIN, 7'd0, 2'd3, 64'd0));
                end
            end
            default:    fail = ERR_MSG;
        endcase
        if (fail != ERR_OK)
            want_msgs.push_back(err_msg(fail));
        else if (!port_is_open)
            want_msgs.push_back(err_msg(ERR_NODEV));
        else
        begin
            seq[seq.size() - 1].last = 1'b1;
            foreach (seq[i])
                want_msgs.push_back(seq[i]);
        end
    endfunction

    // Mostly well-formed; func strays in 4%, chan/key/amt/num may in 10%.
    function automatic midi_req_t random_request();
        midi_req_t r;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 4)
            r.func = 5'($urandom_range(20, 31));
        else if (roll < 9)
            r.func = F_PANIC;
        else
            r.func = 5'($urandom_range(0, 18));
        r.chan = ($urandom_range(9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
        if ($urandom_range(9) == 0)
            r.key = 8'($urandom_range(0, 255));
        else
            r.key = (r.func == F_CC14) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(0, 127));
        if ($urandom_range(9) == 0)
            r.amt = 16'($urandom_range(0, 65535));
        else if (r.func inside {F_BEND, F_CC14, F_RPN, F_NRPN, F_SONGPOS})
            r.amt = 16'($urandom_range(0, 16383));
        else
            r.amt = 16'($urandom_range(0, 127));
        r.num   = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 16383));
        r.stamp = {32'($urandom), 32'($urandom)};
        return r;
    endfunction

    task automatic send_request(input midi_req_t r, input int idle_pct);
        int unsigned gap;
        if ($urandom_range(99) < idle_pct)
        begin
            gap   = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        func         <= r.func;
        channel      <= r.chan;
        key          <= r.key;
        amount       <= r.amt;
        param_number <= r.num;
        timestamp    <= r.stamp;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (want_msgs.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_port_open(input logic v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid    <= 1'b0;
        port_is_open = v;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            if (i == DIR_OPEN_AT)
                write_port_open(1'b1);
            send_request(DIR_TAB[i].req, 0);
            if (!DIR_TAB[i].typed)
                predict_request(DIR_TAB[i].req);
            else if (DIR_TAB[i].err != ERR_OK)
                want_msgs.push_back(err_msg(DIR_TAB[i].err));
            else
            begin
                dir_want      = mk_msg(DIR_TAB[i].status, DIR_TAB[i].d1, DIR_TAB[i].d2,
                                       DIR_TAB[i].cnt, DIR_TAB[i].req.stamp);
                dir_want.last = 1'b1;
                want_msgs.push_back(dir_want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_port_open(PH_OPEN[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                midi_req_t r;
                r = random_request();
                send_request(r, PH_IDLE[p]);
                predict_request(r);
            end
        end

        drain();
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
        begin
            if (want_msgs.size() == 0)
            begin
                $error("unexpected result: status %h err %0d", status_byte, error_code);
                mismatches++;
            end
            else
            begin
                want = want_msgs.pop_front();
                if (status_byte !== want.status)
                begin
                    $error("status_byte: exp %h got %h", want.status, status_byte);
                    mismatches++;
                end
                if (data_first !== want.d1)
                begin
                    $error("data_first: exp %0d got %0d", want.d1, data_first);
                    mismatches++;
                end
                if (data_second !== want.d2)
                begin
                    $error("data_second: exp %0d got %0d", want.d2, data_second);
                    mismatches++;
                end
                if (byte_count !== want.cnt)
                begin
                    $error("byte_count: exp %0d got %0d", want.cnt, byte_count);
                    mismatches++;
                end
                if (send_time !== want.stamp)
                begin
                    $error("send_time: exp %h got %h", want.stamp, send_time);
                    mismatches++;
                end
                if (error_code !== want.err)
                begin
                    $error("error_code: exp %0d got %0d", want.err, error_code);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: exp %0b got %0b", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

endmodule
